/* rtl/core/att_pkg.sv */
// Shared types and codes for the allocation tracking table.
package att_pkg;

  typedef enum logic [2:0] {
    CMD_MALLOC  = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_REALLOC = 3'd2,
    CMD_BEGIN   = 3'd3,
    CMD_END     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addr;
    logic [31:0] size;
  } blk_ent_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] size;
    logic [31:0] now;
    logic [31:0] peak;
    logic [31:0] total;
  } grp_ent_t;

  localparam int BLK_W = $bits(blk_ent_t);
  localparam int GRP_W = $bits(grp_ent_t);

endpackage

/* rtl/core/allocation_tracking_table_unit.sv */
// Allocation tracking table: heap event stream in, one status/statistics item out.
//
// Usage: one event item enters on the in_ channel (valid/stall), one result item
// leaves on the out_ channel. The block works on one event at a time.
// With tracking on, a malloc, free or realloc scans the block table memory
// (one entry a cycle), then the group table memory, then decides and writes
// back (S_GDEC, S_WR1, S_WR2); a free or realloc whose address is not found,
// or has size zero, skips the group scan. The scans use the single read port
// of each table. Begin sweeps the block table; end sweeps both tables.
// Ignored events skip the scans.
// After reset both tables are swept; in_stall is high meanwhile, and no result
// item is produced by reset.
// A finished result sits in the output register; the next event is accepted
// while it waits. If out_stall holds, a second finished result waits inside
// the block until the output register is free.
module allocation_tracking_table_unit #(
  parameter int BLOCK_ENTRIES = 256,
  parameter int GROUP_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_address,
  input  logic [63:0] in_new_address,
  input  logic [31:0] in_block_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_live_count,
  output logic [31:0] out_live_bytes,
  output logic [31:0] out_group_live_now,
  output logic [31:0] out_group_live_peak,
  output logic [31:0] out_group_total
);

  localparam int BW   = $clog2(BLOCK_ENTRIES);
  localparam int GW   = $clog2(GROUP_ENTRIES);
  localparam int MAXD = (BLOCK_ENTRIES > GROUP_ENTRIES) ? BLOCK_ENTRIES : GROUP_ENTRIES;
  localparam int CW   = $clog2(MAXD) + 1;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_BSCAN = 9'b000000100,
    S_BDEC  = 9'b000001000,
    S_GSCAN = 9'b000010000,
    S_GDEC  = 9'b000100000,
    S_WR1   = 9'b001000000,
    S_WR2   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    OP_MALLOC = 2'd0,
    OP_FREE   = 2'd1,
    OP_MOVE   = 2'd2
  } op_t;

  state_t       state_r;
  logic [CW-1:0] cnt_r, ridx_r;
  logic         iss_r, rv_r, clr_grp_r, clr_res_r;
  logic         on_r;
  logic [31:0]  count_r, bytes_r;
  op_t          op_r;
  logic [63:0]  key_r, naddr_r;
  logic [31:0]  size_r;
  logic         fa_r, fn_r, ff_r;
  logic [BW-1:0] fa_idx_r, fn_idx_r, ff_idx_r;
  logic [31:0]  fa_size_r;
  logic         ga_r, gr_r, gf_r;
  logic [GW-1:0] ga_idx_r, gr_idx_r, gf_idx_r;
  att_pkg::grp_ent_t ga_ent_r, gr_ent_r;
  logic         bw1_en_r, bw2_en_r, gw1_en_r, gw2_en_r;
  logic [BW-1:0] bw1_idx_r, bw2_idx_r;
  logic [GW-1:0] gw1_idx_r, gw2_idx_r;
  att_pkg::blk_ent_t bw1_data_r;
  att_pkg::grp_ent_t gw1_data_r, gw2_data_r;
  logic [1:0]   res_status_r;
  logic [31:0]  res_now_r, res_peak_r, res_tot_r;
  logic         out_valid_r;
  logic [1:0]   out_status_r;
  logic [31:0]  out_count_r, out_bytes_r, out_now_r, out_peak_r, out_tot_r;

  logic [att_pkg::BLK_W-1:0] blk_rd_data, blk_wr_data;
  logic [att_pkg::GRP_W-1:0] grp_rd_data, grp_wr_data;
  logic          blk_wr_en, grp_wr_en;
  logic [BW-1:0] blk_wr_idx;
  logic [GW-1:0] grp_wr_idx;
  att_pkg::blk_ent_t blk_e;
  att_pkg::grp_ent_t grp_e;

  logic          accept, scan_last_blk, scan_last_grp, clr_last, done_load;
  op_t           acc_op;
  logic [63:0]   acc_key;
  logic          hit_a, hit_n, hit_free, g_hit_add, g_hit_rem, g_hit_free;
  logic [BW-1:0] blk_slot, move_dst;
  logic          okb, okg, full, move_inv;
  logic [GW-1:0] g_idx;
  att_pkg::grp_ent_t rem_ent, base_ent, add_ent;
  logic [31:0]   add_now;

  att_ram #(.WIDTH(att_pkg::BLK_W), .DEPTH(BLOCK_ENTRIES)) u_blk_ram (
    .clk(clk), .rd_idx(cnt_r[BW-1:0]), .rd_data(blk_rd_data),
    .wr_en(blk_wr_en), .wr_idx(blk_wr_idx), .wr_data(blk_wr_data)
  );

  att_ram #(.WIDTH(att_pkg::GRP_W), .DEPTH(GROUP_ENTRIES)) u_grp_ram (
    .clk(clk), .rd_idx(cnt_r[GW-1:0]), .rd_data(grp_rd_data),
    .wr_en(grp_wr_en), .wr_idx(grp_wr_idx), .wr_data(grp_wr_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_live_count      = out_count_r;
  assign out_live_bytes      = out_bytes_r;
  assign out_group_live_now  = out_now_r;
  assign out_group_live_peak = out_peak_r;
  assign out_group_total     = out_tot_r;

  assign blk_e = att_pkg::blk_ent_t'(blk_rd_data);
  assign grp_e = att_pkg::grp_ent_t'(grp_rd_data);

  assign scan_last_blk = (ridx_r == CW'(BLOCK_ENTRIES - 1));
  assign scan_last_grp = (ridx_r == CW'(GROUP_ENTRIES - 1));
  assign clr_last  = clr_grp_r ? (cnt_r == CW'(MAXD - 1)) : (cnt_r == CW'(BLOCK_ENTRIES - 1));
  assign done_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Realloc from a null address is a malloc at the new address; to size zero, a free.
  always_comb begin
    acc_op  = OP_MALLOC;
    acc_key = in_address;
    case (in_command)
      att_pkg::CMD_FREE: acc_op = OP_FREE;
      att_pkg::CMD_REALLOC: begin
        if (in_address == 64'd0) begin
          acc_op  = OP_MALLOC;
          acc_key = in_new_address;
        end else if (in_block_size == 32'd0) begin
          acc_op = OP_FREE;
        end else begin
          acc_op = OP_MOVE;
        end
      end
      default: acc_op = OP_MALLOC;
    endcase
  end

  assign hit_a      = blk_e.valid && (blk_e.addr == key_r);
  assign hit_n      = blk_e.valid && (blk_e.addr == naddr_r);
  assign hit_free   = !blk_e.valid;
  assign g_hit_add  = grp_e.valid && (grp_e.size == size_r) && (op_r != OP_FREE);
  assign g_hit_rem  = grp_e.valid && (grp_e.size == fa_size_r) && (op_r != OP_MALLOC);
  assign g_hit_free = !grp_e.valid;

  always_comb begin
    blk_slot = fa_r ? fa_idx_r : ff_idx_r;
    okb      = fa_r || ff_r;
    g_idx    = ga_r ? ga_idx_r : gf_idx_r;
    okg      = ga_r || gf_r;
    move_inv = fn_r && (fn_idx_r != fa_idx_r);
    move_dst = move_inv ? fn_idx_r : fa_idx_r;
    rem_ent      = gr_ent_r;
    rem_ent.now  = gr_ent_r.now - 32'd1;
    // When the removed and added sizes share a group, the add starts from the removal.
    if (gr_r && (gr_idx_r == g_idx)) begin
      base_ent = rem_ent;
    end else if (ga_r) begin
      base_ent = ga_ent_r;
    end else begin
      base_ent = '0;
    end
    add_now       = base_ent.now + 32'd1;
    add_ent.valid = 1'b1;
    add_ent.size  = size_r;
    add_ent.now   = add_now;
    add_ent.peak  = (add_now > base_ent.peak) ? add_now : base_ent.peak;
    add_ent.total = base_ent.total + 32'd1;
    case (op_r)
      OP_MALLOC: full = !(okb && okg);
      OP_MOVE:   full = !okg;
      default:   full = 1'b0;
    endcase
  end

  always_comb begin
    blk_wr_en   = 1'b0;
    blk_wr_idx  = cnt_r[BW-1:0];
    blk_wr_data = '0;
    grp_wr_en   = 1'b0;
    grp_wr_idx  = cnt_r[GW-1:0];
    grp_wr_data = '0;
    case (state_r)
      S_CLR: begin
        blk_wr_en = (cnt_r < CW'(BLOCK_ENTRIES));
        grp_wr_en = clr_grp_r && (cnt_r < CW'(GROUP_ENTRIES));
      end
      S_WR1: begin
        blk_wr_en   = bw1_en_r;
        blk_wr_idx  = bw1_idx_r;
        blk_wr_data = bw1_data_r;
        grp_wr_en   = gw1_en_r;
        grp_wr_idx  = gw1_idx_r;
        grp_wr_data = gw1_data_r;
      end
      S_WR2: begin
        blk_wr_en   = bw2_en_r;
        blk_wr_idx  = bw2_idx_r;
        grp_wr_en   = gw2_en_r;
        grp_wr_idx  = gw2_idx_r;
        grp_wr_data = gw2_data_r;
      end
      default: blk_wr_en = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      ridx_r      <= '0;
      iss_r       <= 1'b0;
      rv_r        <= 1'b0;
      clr_grp_r   <= 1'b1;
      clr_res_r   <= 1'b0;
      on_r        <= 1'b0;
      count_r     <= '0;
      bytes_r     <= '0;
      fa_r        <= 1'b0;
      fn_r        <= 1'b0;
      ff_r        <= 1'b0;
      ga_r        <= 1'b0;
      gr_r        <= 1'b0;
      gf_r        <= 1'b0;
      bw1_en_r    <= 1'b0;
      bw2_en_r    <= 1'b0;
      gw1_en_r    <= 1'b0;
      gw2_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      rv_r   <= iss_r && ((state_r == S_BSCAN) || (state_r == S_GSCAN));
      ridx_r <= cnt_r;

      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + CW'(1);
          if (clr_last) begin
            state_r <= clr_res_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt_r <= '0;
            fa_r  <= 1'b0;
            fn_r  <= 1'b0;
            ff_r  <= 1'b0;
            ga_r  <= 1'b0;
            gr_r  <= 1'b0;
            gf_r  <= 1'b0;
            case (in_command)
              att_pkg::CMD_BEGIN: begin
                on_r      <= 1'b1;
                count_r   <= '0;
                bytes_r   <= '0;
                clr_grp_r <= 1'b0;
                clr_res_r <= 1'b1;
                state_r   <= S_CLR;
              end
              att_pkg::CMD_END: begin
                on_r      <= 1'b0;
                count_r   <= '0;
                bytes_r   <= '0;
                clr_grp_r <= 1'b1;
                clr_res_r <= 1'b1;
                state_r   <= S_CLR;
              end
              att_pkg::CMD_MALLOC, att_pkg::CMD_FREE, att_pkg::CMD_REALLOC: begin
                if (on_r) begin
                  iss_r   <= 1'b1;
                  state_r <= S_BSCAN;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_BSCAN: begin
          if (iss_r) begin
            cnt_r <= cnt_r + CW'(1);
            if (cnt_r == CW'(BLOCK_ENTRIES - 1)) begin
              iss_r <= 1'b0;
            end
          end
          if (rv_r) begin
            if (hit_a && !fa_r) begin
              fa_r <= 1'b1;
            end
            if (hit_n && !fn_r) begin
              fn_r <= 1'b1;
            end
            if (hit_free && !ff_r) begin
              ff_r <= 1'b1;
            end
            if (scan_last_blk) begin
              state_r <= S_BDEC;
            end
          end
        end
        S_BDEC: begin
          if ((op_r != OP_MALLOC) && (!fa_r || (fa_size_r == 32'd0))) begin
            state_r <= S_DONE;
          end else begin
            cnt_r   <= '0;
            iss_r   <= 1'b1;
            state_r <= S_GSCAN;
          end
        end
        S_GSCAN: begin
          if (iss_r) begin
            cnt_r <= cnt_r + CW'(1);
            if (cnt_r == CW'(GROUP_ENTRIES - 1)) begin
              iss_r <= 1'b0;
            end
          end
          if (rv_r) begin
            if (g_hit_add && !ga_r) begin
              ga_r <= 1'b1;
            end
            if (g_hit_rem && !gr_r) begin
              gr_r <= 1'b1;
            end
            if (g_hit_free && !gf_r) begin
              gf_r <= 1'b1;
            end
            if (scan_last_grp) begin
              state_r <= S_GDEC;
            end
          end
        end
        S_GDEC: begin
          state_r  <= S_WR1;
          bw1_en_r <= !full;
          bw2_en_r <= !full && (op_r == OP_MOVE) && move_inv;
          gw1_en_r <= !full && (op_r != OP_MALLOC) && gr_r;
          gw2_en_r <= !full && (op_r != OP_FREE);
          if (!full) begin
            case (op_r)
              OP_MALLOC: begin
                count_r  <= count_r + 32'd1;
                bytes_r  <= bytes_r + size_r;
              end
              OP_FREE: begin
                count_r  <= count_r - 32'd1;
                bytes_r  <= bytes_r - fa_size_r;
              end
              default: begin
                bytes_r  <= bytes_r - fa_size_r + size_r;
              end
            endcase
          end
        end
        S_WR1: state_r <= S_WR2;
        S_WR2: state_r <= S_DONE;
        S_DONE: begin
          if (done_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r         <= acc_op;
        key_r        <= acc_key;
        naddr_r      <= in_new_address;
        size_r       <= in_block_size;
        res_status_r <= ((in_command == att_pkg::CMD_BEGIN) ||
                         (in_command == att_pkg::CMD_END)) ?
                        att_pkg::ST_APPLIED : att_pkg::ST_IGNORED;
        res_now_r    <= '0;
        res_peak_r   <= '0;
        res_tot_r    <= '0;
      end
      S_BSCAN: begin
        if (rv_r) begin
          if (hit_a && !fa_r) begin
            fa_idx_r  <= ridx_r[BW-1:0];
            fa_size_r <= blk_e.size;
          end
          if (hit_n && !fn_r) begin
            fn_idx_r <= ridx_r[BW-1:0];
          end
          if (hit_free && !ff_r) begin
            ff_idx_r <= ridx_r[BW-1:0];
          end
        end
      end
      S_BDEC: res_status_r <= att_pkg::ST_UNKNOWN;
      S_GSCAN: begin
        if (rv_r) begin
          if (g_hit_add && !ga_r) begin
            ga_idx_r <= ridx_r[GW-1:0];
            ga_ent_r <= grp_e;
          end
          if (g_hit_rem && !gr_r) begin
            gr_idx_r <= ridx_r[GW-1:0];
            gr_ent_r <= grp_e;
          end
          if (g_hit_free && !gf_r) begin
            gf_idx_r <= ridx_r[GW-1:0];
          end
        end
      end
      S_GDEC: begin
        bw2_idx_r  <= fa_idx_r;
        gw1_idx_r  <= gr_idx_r;
        gw1_data_r <= rem_ent;
        gw2_idx_r  <= g_idx;
        gw2_data_r <= add_ent;
        if (full) begin
          res_status_r <= att_pkg::ST_FULL;
        end else begin
          res_status_r <= att_pkg::ST_APPLIED;
          case (op_r)
            OP_MALLOC: begin
              bw1_idx_r  <= blk_slot;
              bw1_data_r <= '{valid: 1'b1, addr: key_r, size: size_r};
              res_now_r  <= add_ent.now;
              res_peak_r <= add_ent.peak;
              res_tot_r  <= add_ent.total;
            end
            OP_FREE: begin
              bw1_idx_r  <= fa_idx_r;
              bw1_data_r <= '0;
              res_now_r  <= gr_r ? rem_ent.now : 32'd0;
              res_peak_r <= gr_r ? rem_ent.peak : 32'd0;
              res_tot_r  <= gr_r ? rem_ent.total : 32'd0;
            end
            default: begin
              bw1_idx_r  <= move_dst;
              bw1_data_r <= '{valid: 1'b1, addr: naddr_r, size: size_r};
              res_now_r  <= add_ent.now;
              res_peak_r <= add_ent.peak;
              res_tot_r  <= add_ent.total;
            end
          endcase
        end
      end
      default: res_status_r <= res_status_r;
    endcase
    if (done_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
      out_bytes_r  <= bytes_r;
      out_now_r    <= res_now_r;
      out_peak_r   <= res_peak_r;
      out_tot_r    <= res_tot_r;
    end
  end

endmodule

/* rtl/core/att_ram.sv */
// Single-port-write, registered-read memory used for the block and group tables.
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

/* rtl/core/att_checker.sv */
// Port-level checks for the allocation tracking table, bound to the top level.
module att_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_group_live_now,
  input logic [31:0] out_group_live_peak,
  input logic [31:0] out_group_total
);

  // The block takes one event at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("event accepted while another is in progress");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == att_pkg::ST_APPLIED) |->
      out_group_live_peak >= out_group_live_now)
    else $error("group peak below live count");

  a_ignored_no_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == att_pkg::ST_IGNORED) |->
      (out_group_live_now == 32'd0) && (out_group_live_peak == 32'd0) &&
      (out_group_total == 32'd0))
    else $error("ignored event reports group statistics");

endmodule

bind allocation_tracking_table_unit att_checker u_att_checker (.*);

/* tb/tb.sv */
// Testbench for the allocation tracking table: random and directed heap events, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 256;
  localparam int NGRP = 64;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [63:0] naddr;
    logic [31:0] size;
    bit          drain;
  } event_t;

  typedef struct {
    att_pkg::status_t st;
    logic [31:0] cnt;
    logic [31:0] bytes;
    logic [31:0] gnow;
    logic [31:0] gpeak;
    logic [31:0] gtot;
  } stats_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [63:0] in_address = '0;
  logic [63:0] in_new_address = '0;
  logic [31:0] in_block_size = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [31:0] out_live_count, out_live_bytes;
  logic [31:0] out_group_live_now, out_group_live_peak, out_group_total;

  allocation_tracking_table_unit dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the tracker state.
  bit          trk_on;
  bit [31:0]   blk_count, byte_sum;
  bit          bv[NBLK];
  bit [63:0]   ba[NBLK];
  bit [31:0]   bs[NBLK];
  bit          gv[NGRP];
  bit [31:0]   gsz[NGRP], gnow[NGRP], gpeak[NGRP], gtot[NGRP];

  event_t pending[$];
  stats_t expected_stats[$];
  event_t cur;
  bit     in_fired;
  int     gap_left = 0, hold_left = 0, accepted = 0, errors = 0;
  bit     long_hold_done = 0;

  function automatic int find_blk(logic [63:0] a);
    for (int i = 0; i < NBLK; i++) if (bv[i] && ba[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_grp(logic [31:0] s);
    for (int i = 0; i < NGRP; i++) if (gv[i] && gsz[i] == s) return i;
    return -1;
  endfunction

  function automatic int grp_slot(logic [31:0] s);
    int g;
    g = find_grp(s);
    if (g >= 0) return g;
    for (int i = 0; i < NGRP; i++) if (!gv[i]) return i;
    return -1;
  endfunction

  function automatic void clear_all(bit groups_too);
    blk_count = 0;
    byte_sum = 0;
    for (int i = 0; i < NBLK; i++) bv[i] = 0;
    if (groups_too) for (int i = 0; i < NGRP; i++) gv[i] = 0;
  endfunction

  function automatic void add_size(int g, logic [31:0] s);
    blk_count++;
    byte_sum += s;
    if (!gv[g]) begin
      gv[g] = 1; gsz[g] = s; gnow[g] = 0; gpeak[g] = 0; gtot[g] = 0;
    end
    gnow[g]++;
    if (gnow[g] > gpeak[g]) gpeak[g] = gnow[g];
    gtot[g]++;
  endfunction

  function automatic int drop_size(logic [31:0] s);
    int g;
    blk_count--;
    byte_sum -= s;
    g = find_grp(s);
    if (g >= 0) gnow[g]--;
    return g;
  endfunction

  function automatic att_pkg::status_t do_malloc(logic [63:0] a, logic [31:0] s, ref int g);
    int b;
    int gg;
    b = find_blk(a);
    if (b < 0) for (int i = 0; i < NBLK; i++) if (!bv[i]) begin b = i; break; end
    gg = grp_slot(s);
    if (b < 0 || gg < 0) return att_pkg::ST_FULL;
    bv[b] = 1; ba[b] = a; bs[b] = s;
    add_size(gg, s);
    g = gg;
    return att_pkg::ST_APPLIED;
  endfunction

  function automatic att_pkg::status_t do_free(logic [63:0] a, ref int g);
    int b;
    b = find_blk(a);
    if (b < 0 || bs[b] == 0) return att_pkg::ST_UNKNOWN;
    g = drop_size(bs[b]);
    bv[b] = 0;
    return att_pkg::ST_APPLIED;
  endfunction

  function automatic att_pkg::status_t do_realloc(logic [63:0] a, logic [63:0] na,
                                                  logic [31:0] s, ref int g);
    int b, d, gg, unused;
    logic [31:0] olds;
    if (a == 0) return do_malloc(na, s, g);
    if (s == 0) return do_free(a, g);
    b = find_blk(a);
    if (b < 0 || bs[b] == 0) return att_pkg::ST_UNKNOWN;
    gg = grp_slot(s);
    if (gg < 0) return att_pkg::ST_FULL;
    olds = bs[b];
    d = find_blk(na);
    if (d >= 0 && d != b) begin
      bv[b] = 0;
      b = d;
    end
    bv[b] = 1; ba[b] = na; bs[b] = s;
    unused = drop_size(olds);
    add_size(gg, s);
    g = gg;
    return att_pkg::ST_APPLIED;
  endfunction

  function automatic stats_t track_event(logic [2:0] c, logic [63:0] a, logic [63:0] na,
                                         logic [31:0] s);
    stats_t r;
    int g;
    g = -1;
    r.st = att_pkg::ST_IGNORED;
    if (c == att_pkg::CMD_BEGIN) begin
      clear_all(0);
      trk_on = 1;
      r.st = att_pkg::ST_APPLIED;
    end else if (c == att_pkg::CMD_END) begin
      clear_all(1);
      trk_on = 0;
      r.st = att_pkg::ST_APPLIED;
    end else if (trk_on && c == att_pkg::CMD_MALLOC) r.st = do_malloc(a, s, g);
    else if (trk_on && c == att_pkg::CMD_FREE) r.st = do_free(a, g);
    else if (trk_on && c == att_pkg::CMD_REALLOC) r.st = do_realloc(a, na, s, g);
    r.cnt = blk_count;
    r.bytes = byte_sum;
    r.gnow = (g >= 0) ? gnow[g] : '0;
    r.gpeak = (g >= 0) ? gpeak[g] : '0;
    r.gtot = (g >= 0) ? gtot[g] : '0;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Input acceptance, prediction and result checking.
  always @(posedge clk) begin
    stats_t e;
    in_fired = rst_n && in_valid && !in_stall;
    if (in_fired) begin
      accepted++;
      expected_stats.push_back(track_event(in_command, in_address, in_new_address,
                                           in_block_size));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected, status %0d", $time, out_status);
      end else begin
        e = expected_stats.pop_front();
        check_field("status", 32'(e.st), 32'(out_status));
        check_field("live_count", e.cnt, out_live_count);
        check_field("live_bytes", e.bytes, out_live_bytes);
        check_field("group_live_now", e.gnow, out_group_live_now);
        check_field("group_live_peak", e.gpeak, out_group_live_peak);
        check_field("group_total", e.gtot, out_group_total);
      end
    end
  end

  // Driver: an item marked drain waits until every earlier result is back.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_fired) begin
      if (gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending.size() > 0 && !(pending[0].drain && expected_stats.size() > 0)) begin
        cur = pending.pop_front();
        in_command <= cur.cmd;
        in_address <= cur.addr;
        in_new_address <= cur.naddr;
        in_block_size <= cur.size;
        in_valid <= 1;
        if (pending.size() > 80 && $urandom_range(0, 6) == 0)
          gap_left <= $urandom_range(1, 13);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver stalls; one long hold-off fills the block while items keep coming.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (!long_hold_done && accepted == 150) begin
      long_hold_done <= 1;
      hold_left <= 3000;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (pending.size() > 80 && $urandom_range(0, 8) == 0) begin
      out_stall <= 1;
      hold_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 0;
    end
  end

  task automatic push_event(logic [2:0] c, logic [63:0] a, logic [63:0] na, logic [31:0] s,
                            bit drain = 0);
    event_t ev;
    ev.cmd = c; ev.addr = a; ev.naddr = na; ev.size = s; ev.drain = drain;
    pending.push_back(ev);
  endtask

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return '1;
      2: return '0;
      default: return 64'h100 * $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return '1;
      2: return '0;
      default: return 32'd8 << $urandom_range(0, 5);
    endcase
  endfunction

  initial begin
    int r;
    // Directed events.
    push_event(att_pkg::CMD_MALLOC, 64'h10, 0, 32'd4);
    push_event(att_pkg::CMD_BEGIN, 0, 0, 0);
    push_event(att_pkg::CMD_MALLOC, '1, 0, '1);
    push_event(att_pkg::CMD_MALLOC, 64'h20, 0, 32'd0);
    push_event(att_pkg::CMD_FREE, 64'h20, 0, 0);
    push_event(att_pkg::CMD_FREE, 64'h30, 0, 0);
    push_event(att_pkg::CMD_REALLOC, 64'h30, 64'h40, 32'd16);
    push_event(att_pkg::CMD_REALLOC, 64'h0, 64'h50, 32'd16);
    push_event(att_pkg::CMD_MALLOC, 64'h50, 0, 32'd32);
    push_event(att_pkg::CMD_MALLOC, 64'h60, 0, 32'd16);
    push_event(att_pkg::CMD_REALLOC, 64'h50, 64'h60, 32'd24);
    push_event(att_pkg::CMD_REALLOC, 64'h60, 64'h60, 32'd48);
    push_event(att_pkg::CMD_REALLOC, 64'h60, 64'h70, 32'd0);
    push_event(att_pkg::CMD_FREE, '1, 0, 0);
    push_event(3'd5, 64'h10, 0, 32'd4);
    push_event(3'd6, 0, 0, 0);
    push_event(3'd7, '1, '1, '1);
    push_event(att_pkg::CMD_BEGIN, 0, 0, 0);
    push_event(att_pkg::CMD_MALLOC, 64'h80, 0, 32'd16);
    push_event(att_pkg::CMD_END, 0, 0, 0);
    push_event(att_pkg::CMD_FREE, 64'h80, 0, 0);
    // Fill the block table until a malloc finds no free entry.
    push_event(att_pkg::CMD_BEGIN, 0, 0, 0);
    for (int i = 0; i < NBLK + 2; i++)
      push_event(att_pkg::CMD_MALLOC, 64'h10000 + 16 * i, 0, 32'd8 << (i % 4));
    push_event(att_pkg::CMD_FREE, 64'h10000, 0, 0);
    push_event(att_pkg::CMD_MALLOC, 64'h90000, 0, 32'd8);
    push_event(att_pkg::CMD_END, 0, 0, 0);
    // Fill the group table with distinct sizes; wait for an empty pipe first.
    push_event(att_pkg::CMD_BEGIN, 0, 0, 0, 1);
    for (int i = 0; i < NGRP + 2; i++)
      push_event(att_pkg::CMD_MALLOC, 64'h20000 + 16 * i, 0, 32'(i + 1));
    push_event(att_pkg::CMD_REALLOC, 64'h20000, 64'h20000, 32'd999);
    push_event(att_pkg::CMD_END, 0, 0, 0);
    push_event(att_pkg::CMD_BEGIN, 0, 0, 0);
    // Random heap traffic, mostly with tracking on.
    for (int i = 0; i < 480; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38)
        push_event(att_pkg::CMD_MALLOC, pick_addr(), {$urandom, $urandom}, pick_size());
      else if (r < 62)
        push_event(att_pkg::CMD_FREE, pick_addr(), {$urandom, $urandom}, $urandom);
      else if (r < 92)
        push_event(att_pkg::CMD_REALLOC, pick_addr(), pick_addr(), pick_size());
      else if (r < 95)
        push_event(3'($urandom_range(att_pkg::CMD_END + 1, 7)), pick_addr(), pick_addr(),
                   $urandom);
      else if (r < 97) push_event(att_pkg::CMD_BEGIN, pick_addr(), 0, $urandom);
      else begin
        push_event(att_pkg::CMD_END, pick_addr(), pick_addr(), $urandom);
        if ($urandom_range(0, 1)) push_event(att_pkg::CMD_BEGIN, 0, 0, 0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1;
    wait (pending.size() == 0 && !in_valid && expected_stats.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/att_pkg.sv
rtl/core/att_ram.sv
rtl/core/allocation_tracking_table_unit.sv
rtl/core/att_checker.sv
tb/tb.sv
